// ----- rtl/core/uwc_pkg.sv -----
// uwc_pkg: shared types, constants and the whitespace lookup for the utf-8 collapser
// used by uwc_front, uwc_fifo, uwc_back and utf8_whitespace_collapser
package uwc_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [7:0]  SpaceByte = 8'h20;
  localparam logic [20:0] MinTwo    = 21'h000080;
  localparam logic [20:0] MinThree  = 21'h000800;
  localparam logic [20:0] MinFour   = 21'h010000;
  localparam logic [20:0] MaxPoint  = 21'h10FFFF;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_END,
    CMD_ERR
  } cmd_kind_e;

  // one queued command: a space and/or character bytes, an end-only mark or an error
  typedef struct packed {
    cmd_kind_e       kind;
    logic [3:0][7:0] bytes;
    logic [1:0]      count;
    logic            space;
    logic            last;
  } cmd_t;

  function automatic logic is_space_point(logic [20:0] cp);
    return cp inside {21'h0009, 21'h000A, 21'h000B, 21'h000C, 21'h000D,
                      21'h001C, 21'h001D, 21'h001E, 21'h001F, 21'h0020,
                      21'h0085, 21'h00A0, 21'h1680,
                      [21'h2000 : 21'h200A],
                      21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000};
  endfunction

endpackage

// ----- rtl/core/uwc_front.sv -----
// uwc_front: utf-8 decode, validation and whitespace run tracking
// depends on uwc_pkg; emits one command per item that gives results
module uwc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          push_o,
  output uwc_pkg::cmd_t cmd_o
);
  import uwc_pkg::*;

  logic [20:0]     pp_q, pp_d;
  logic [1:0]      due_q, due_d;
  logic [1:0]      len_q, len_d;
  logic [3:0][7:0] held_q, held_d;
  logic            sp_q, sp_d;
  logic            sent_q, sent_d;
  logic            skip_q, skip_d;

  logic        complete;
  logic        err;
  logic [20:0] cp;
  logic [1:0]  cnt;
  logic [20:0] ppn;
  logic [1:0]  idx;
  logic [20:0] minimum;

  assign ppn = {pp_q[14:0], byte_i[5:0]};
  assign idx = len_q - due_q + 2'd1;

  always_comb begin
    pp_d     = pp_q;
    due_d    = due_q;
    len_d    = len_q;
    held_d   = held_q;
    sp_d     = sp_q;
    sent_d   = sent_q;
    skip_d   = skip_q;
    complete = 1'b0;
    err      = 1'b0;
    cp       = '0;
    cnt      = '0;
    minimum  = MinFour;
    push_o   = 1'b0;
    cmd_o    = '{kind: CMD_DATA, bytes: held_q, count: 2'd0, space: 1'b0, last: 1'b0};
    if (fire_i) begin
      if (skip_q) begin
        if (last_i) begin
          skip_d = 1'b0;
          pp_d   = '0;
          due_d  = '0;
          len_d  = '0;
          sp_d   = 1'b0;
          sent_d = 1'b0;
        end
      end else if (due_q == 2'd0) begin
        held_d[0] = byte_i;
        if (!byte_i[7]) begin
          cp       = {13'd0, byte_i};
          complete = 1'b1;
        end else if (byte_i[7:5] == 3'b110) begin
          pp_d  = {16'd0, byte_i[4:0]};
          len_d = 2'd1;
          due_d = 2'd1;
          err   = last_i;
        end else if (byte_i[7:4] == 4'b1110) begin
          pp_d  = {17'd0, byte_i[3:0]};
          len_d = 2'd2;
          due_d = 2'd2;
          err   = last_i;
        end else if (byte_i[7:3] == 5'b11110) begin
          pp_d  = {18'd0, byte_i[2:0]};
          len_d = 2'd3;
          due_d = 2'd3;
          err   = last_i;
        end else begin
          err = 1'b1;
        end
      end else begin
        if (byte_i[7:6] != 2'b10) begin
          err = 1'b1;
        end else begin
          held_d[idx] = byte_i;
          due_d       = due_q - 2'd1;
          if (due_q != 2'd1) begin
            pp_d = ppn;
            err  = last_i;
          end else begin
            cp  = ppn;
            cnt = len_q;
            case (len_q)
              2'd1:    minimum = MinTwo;
              2'd2:    minimum = MinThree;
              default: minimum = MinFour;
            endcase
            if (cp < minimum || cp > MaxPoint || (cp >= SurrLo && cp <= SurrHi)) begin
              err = 1'b1;
            end else begin
              pp_d     = '0;
              len_d    = '0;
              complete = 1'b1;
            end
          end
        end
      end

      cmd_o.bytes = held_d;
      if (complete) begin
        if (is_space_point(cp)) begin
          sp_d = sent_q;
        end else begin
          push_o      = 1'b1;
          cmd_o.kind  = CMD_DATA;
          cmd_o.space = sp_q;
          cmd_o.count = cnt;
          sp_d        = 1'b0;
          sent_d      = 1'b1;
        end
        if (last_i) begin
          if (!push_o) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_END;
          end
          cmd_o.last = 1'b1;
          pp_d       = '0;
          due_d      = '0;
          len_d      = '0;
          sp_d       = 1'b0;
          sent_d     = 1'b0;
        end
      end

      if (err) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_ERR;
        cmd_o.last = 1'b1;
        skip_d     = !last_i;
        pp_d       = '0;
        due_d      = '0;
        len_d      = '0;
        sp_d       = 1'b0;
        sent_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      due_q  <= '0;
      len_q  <= '0;
      sp_q   <= 1'b0;
      sent_q <= 1'b0;
      skip_q <= 1'b0;
    end else begin
      pp_q   <= pp_d;
      due_q  <= due_d;
      len_q  <= len_d;
      sp_q   <= sp_d;
      sent_q <= sent_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ----- rtl/core/uwc_fifo.sv -----
// uwc_fifo: short command queue between the decode front and the output back
// depends on uwc_pkg for cmd_t and the queue depth
module uwc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uwc_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output uwc_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import uwc_pkg::*;

  cmd_t           mem_q [QDepth];
  logic [QAw-1:0] wptr_q, wptr_d;
  logic [QAw-1:0] rptr_q, rptr_d;
  logic [QAw:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QDepth[QAw:0]);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/uwc_back.sv -----
// uwc_back: expands queued commands into output items, one per cycle while ready_i is high
// depends on uwc_pkg; holds the command being sent as the output register
module uwc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  uwc_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [7:0]    byte_o,
  output logic          present_o,
  output logic          last_o,
  output logic          bad_o
);
  import uwc_pkg::*;

  cmd_t       cur_q, cur_d;
  logic       vld_q, vld_d;
  logic [2:0] step_q, step_d;

  logic       at_end;
  logic       fire;
  logic [2:0] bsel;

  assign fire    = vld_q && ready_i;
  assign valid_o = vld_q;
  assign bsel    = step_q - {2'd0, cur_q.space};

  always_comb begin
    at_end    = 1'b1;
    byte_o    = 8'd0;
    present_o = 1'b0;
    last_o    = cur_q.last;
    bad_o     = 1'b0;
    case (cur_q.kind)
      CMD_DATA: begin
        at_end    = (step_q == ({1'b0, cur_q.count} + {2'd0, cur_q.space}));
        present_o = 1'b1;
        last_o    = at_end && cur_q.last;
        if (cur_q.space && step_q == 3'd0) begin
          byte_o = SpaceByte;
        end else begin
          byte_o = cur_q.bytes[bsel[1:0]];
        end
      end
      CMD_ERR: begin
        bad_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cur_d  = cur_q;
    vld_d  = vld_q;
    step_d = step_q;
    pop_o  = (!vld_q || (fire && at_end)) && !empty_i;
    if (pop_o) begin
      cur_d  = cmd_i;
      vld_d  = 1'b1;
      step_d = '0;
    end else if (fire) begin
      if (at_end) begin
        vld_d = 1'b0;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      step_q <= '0;
    end else begin
      vld_q  <= vld_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// ----- rtl/core/utf8_whitespace_collapser.sv -----
// utf8_whitespace_collapser: top level, decode front, command queue and output back
// depends on uwc_pkg, uwc_front, uwc_fifo and uwc_back
//
//   channel   dir  tdata          tuser                          tlast
//   s_axis    in   in_byte[7:0]   -                              in_last
//   m_axis    out  out_byte[7:0]  [0] byte_present [1] bad_text  out_last
//
// input side takes one byte per cycle while the 4-entry command queue has room
// output side sends one item per cycle while m_axis_tready is high; a command holds up to
// five items (space plus a 4-byte character)
// a stalled output only stops the input once the queue is full
// reset clears all control state at once; no clearing pass
module utf8_whitespace_collapser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser,  // [0] byte_present, [1] bad_text
  output logic       m_axis_tlast
);
  import uwc_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  logic s_fire;
  cmd_t wcmd;
  cmd_t rcmd;

  assign s_axis_tready = !q_full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  uwc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s_fire),
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .push_o (push),
    .cmd_o  (wcmd)
  );

  uwc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wcmd),
    .pop_i   (pop),
    .rdata_o (rcmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  uwc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (rcmd),
    .empty_i   (q_empty),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .byte_o    (m_axis_tdata),
    .present_o (m_axis_tuser[0]),
    .last_o    (m_axis_tlast),
    .bad_o     (m_axis_tuser[1])
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  a_err_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("error item without end mark or with data");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0 && m_axis_tlast))
    else $error("dataless item carries a byte or no end mark");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("command taken from an empty queue");

endmodule

// ----- test/tb_utf8_whitespace_collapser.sv -----
// testbench for utf8_whitespace_collapser: directed and random utf-8 texts on the input stream,
// every output item checked against a behavioral prediction of decode, validation and collapse
// depends on uwc_pkg and utf8_whitespace_collapser
`timescale 1ns / 100ps

module tb_utf8_whitespace_collapser;
  import uwc_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;

  localparam logic [20:0] BlankPoints [29] = '{
    21'h0009, 21'h000A, 21'h000B, 21'h000C, 21'h000D, 21'h001C, 21'h001D, 21'h001E,
    21'h001F, 21'h0020, 21'h0085, 21'h00A0, 21'h1680, 21'h2000, 21'h2001, 21'h2002,
    21'h2003, 21'h2004, 21'h2005, 21'h2006, 21'h2007, 21'h2008, 21'h2009, 21'h200A,
    21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000
  };

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       bad;
  } out_item_t;

  typedef enum {CH_ASCII, CH_TWO, CH_THREE, CH_FOUR, CH_BLANK} char_kind_e;
  typedef enum {
    FAULT_LEAD, FAULT_CONT, FAULT_OVERLONG, FAULT_SURROGATE, FAULT_ABOVE, FAULT_CUT
  } fault_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  utf8_whitespace_collapser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // decoder state of the prediction
  logic [20:0] part_cp     = '0;
  logic [1:0]  cont_due    = '0;
  logic [1:0]  cont_total  = '0;
  logic [7:0]  char_bytes [4];
  logic        blank_owed  = 1'b0;
  logic        text_begun  = 1'b0;
  logic        discarding  = 1'b0;

  out_item_t   expected_items [$];
  logic [7:0]  pending_text [$];
  int          error_count  = 0;
  int          live_items   = 0;
  int          quiet_cycles = 0;
  bit          calm         = 1'b0;

  function automatic logic is_blank(input logic [20:0] cp);
    int k;
    for (k = 0; k < 29; k++) begin
      if (BlankPoints[k] == cp) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic expect_item(input out_item_t it);
    expected_items.insert(expected_items.size(), it);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_text.insert(pending_text.size(), b);
  endtask

  task automatic clear_text_state();
    part_cp    = '0;
    cont_due   = '0;
    cont_total = '0;
    blank_owed = 1'b0;
    text_begun = 1'b0;
  endtask

  task automatic flag_bad_text(input logic fin);
    clear_text_state();
    discarding = !fin;
    expect_item({8'h00, 1'b0, 1'b1, 1'b1});
  endtask

  task automatic collapse_byte(input logic [7:0] b, input logic fin);
    out_item_t   step_items [5];
    int          n;
    int          k;
    int          cnt;
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [1:0]  slot;
    n   = 0;
    cnt = 0;
    cp  = '0;
    if (discarding) begin
      if (fin) begin
        discarding = 1'b0;
        clear_text_state();
      end
      return;
    end
    if (cont_due == 2'd0) begin
      char_bytes[0] = b;
      if (!b[7]) begin
        cp = {13'd0, b};
      end else begin
        if (b[7:5] == 3'b110) begin
          part_cp    = {16'd0, b[4:0]};
          cont_total = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          part_cp    = {17'd0, b[3:0]};
          cont_total = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          part_cp    = {18'd0, b[2:0]};
          cont_total = 2'd3;
        end else begin
          flag_bad_text(fin);
          return;
        end
        cont_due = cont_total;
        if (fin) flag_bad_text(fin);
        return;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        flag_bad_text(fin);
        return;
      end
      slot             = cont_total - cont_due + 2'd1;
      char_bytes[slot] = b;
      part_cp          = {part_cp[14:0], b[5:0]};
      cont_due         = cont_due - 2'd1;
      if (cont_due != 2'd0) begin
        if (fin) flag_bad_text(fin);
        return;
      end
      cp  = part_cp;
      cnt = int'(cont_total);
      case (cnt)
        1:       floor_cp = MinTwo;
        2:       floor_cp = MinThree;
        default: floor_cp = MinFour;
      endcase
      if (cp < floor_cp || cp > MaxPoint || (cp >= SurrLo && cp <= SurrHi)) begin
        flag_bad_text(fin);
        return;
      end
      part_cp    = '0;
      cont_total = '0;
    end

    if (is_blank(cp)) begin
      blank_owed = text_begun;
    end else begin
      if (blank_owed) begin
        step_items[n] = {SpaceByte, 1'b1, 1'b0, 1'b0};
        n++;
      end
      for (k = 0; k <= cnt; k++) begin
        step_items[n] = {char_bytes[k], 1'b1, 1'b0, 1'b0};
        n++;
      end
      blank_owed = 1'b0;
      text_begun = 1'b1;
    end

    if (fin) begin
      if (n == 0) begin
        step_items[n] = {8'h00, 1'b0, 1'b1, 1'b0};
        n++;
      end else begin
        step_items[n-1].last = 1'b1;
      end
      clear_text_state();
    end
    for (k = 0; k < n; k++) expect_item(step_items[k]);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      live_items++;
      collapse_byte(s_axis_tdata, s_axis_tlast);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_items.size() == 0) begin
        $error("unexpected item: out_byte %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = expected_items.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.present) begin
          $error("byte_present: expected %b, got %b", want.present, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tuser[1] !== want.bad) begin
          $error("bad_text: expected %b, got %b", want.bad, m_axis_tuser[1]);
          error_count++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_utf8_whitespace_collapser: done, errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text();
    int k;
    for (k = 0; k < pending_text.size(); k++) begin
      send_byte(pending_text[k], k == pending_text.size() - 1);
    end
    pending_text.delete();
  endtask

  task automatic encode_point(input logic [20:0] cp, input int len);
    case (len)
      1: queue_byte(cp[7:0]);
      2: begin
        queue_byte({3'b110, cp[10:6]});
        queue_byte({2'b10, cp[5:0]});
      end
      3: begin
        queue_byte({4'b1110, cp[15:12]});
        queue_byte({2'b10, cp[11:6]});
        queue_byte({2'b10, cp[5:0]});
      end
      default: begin
        queue_byte({5'b11110, cp[20:18]});
        queue_byte({2'b10, cp[17:12]});
        queue_byte({2'b10, cp[11:6]});
        queue_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int kind_length(input char_kind_e kind);
    case (kind)
      CH_TWO:   return 2;
      CH_THREE: return 3;
      CH_FOUR:  return 4;
      default:  return 1;
    endcase
  endfunction

  task automatic add_char(input char_kind_e kind);
    logic [20:0] cp;
    int          len;
    len = kind_length(kind);
    case (kind)
      CH_ASCII: cp = 21'($urandom_range(0, 127));
      CH_TWO:   cp = 21'($urandom_range(32'(MinTwo), 32'(MinThree) - 1));
      CH_THREE: begin
        do cp = 21'($urandom_range(32'(MinThree), 32'(MinFour) - 1));
        while (cp >= SurrLo && cp <= SurrHi);
      end
      CH_FOUR:  cp = 21'($urandom_range(32'(MinFour), 32'(MaxPoint)));
      default: begin
        cp  = BlankPoints[$urandom_range(0, 28)];
        len = (cp < MinTwo) ? 1 : (cp < MinThree) ? 2 : 3;
      end
    endcase
    encode_point(cp, len);
  endtask

  function automatic char_kind_e pick_char_kind();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 35) return CH_BLANK;
    if (r < 60) return CH_ASCII;
    if (r < 75) return CH_TWO;
    if (r < 90) return CH_THREE;
    return CH_FOUR;
  endfunction

  task automatic add_chars(input int count);
    int k;
    for (k = 0; k < count; k++) add_char(pick_char_kind());
  endtask

  task automatic add_fault();
    fault_kind_e fault;
    char_kind_e  kind;
    int          len;
    int          k;
    int          pos;
    logic [7:0]  junk;
    fault = fault_kind_e'($urandom_range(0, 5));
    kind  = char_kind_e'($urandom_range(int'(CH_TWO), int'(CH_FOUR)));
    len   = kind_length(kind);
    case (fault)
      FAULT_LEAD: begin
        if ($urandom_range(0, 1) == 1) junk = 8'($urandom_range(8'h80, 8'hBF));
        else junk = 8'($urandom_range(8'hF8, 8'hFF));
        queue_byte(junk);
      end
      FAULT_CONT: begin
        add_char(kind);
        pos = pending_text.size() - int'($urandom_range(1, len - 1));
        do junk = 8'($urandom); while (junk[7:6] == 2'b10);
        pending_text[pos] = junk;
      end
      FAULT_OVERLONG: begin
        case (len)
          2:       encode_point(21'($urandom_range(0, 32'(MinTwo) - 1)), 2);
          3:       encode_point(21'($urandom_range(0, 32'(MinThree) - 1)), 3);
          default: encode_point(21'($urandom_range(0, 32'(MinFour) - 1)), 4);
        endcase
      end
      FAULT_SURROGATE: encode_point(21'($urandom_range(32'(SurrLo), 32'(SurrHi))), 3);
      FAULT_ABOVE: encode_point(21'($urandom_range(32'(MaxPoint) + 1, 32'h1FFFFF)), 4);
      default: begin
        add_char(kind);
        for (k = int'($urandom_range(1, len - 1)); k > 0; k--) void'(pending_text.pop_back());
      end
    endcase
  endtask

  task automatic test_directed_cases();
    // leading blank dropped, blank run before a 4-byte maximum, trailing run gives end-only
    pending_text = '{8'h20, 8'h41, 8'h09, 8'hC2, 8'hA0, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'hE3, 8'h80, 8'h80};
    send_text();
    pending_text = '{8'hFF};
    send_text();
    // bad continuation mid-text, rest skipped up to the mark
    pending_text = '{8'hC3, 8'h41, 8'h0A};
    send_text();
    pending_text = '{8'hC0, 8'h80};
    send_text();
    pending_text = '{8'hED, 8'hA0, 8'h80};
    send_text();
    pending_text = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
    pending_text = '{8'hE2};
    send_text();
    pending_text = '{8'h00};
    send_text();
  endtask

  task automatic test_wellformed_text();
    int start;
    start = live_items;
    while (live_items - start < 150) begin
      calm = (live_items - start >= 40) && (live_items - start < 110);
      add_chars(int'($urandom_range(1, 10)));
      send_text();
    end
    calm = 1'b0;
  endtask

  task automatic test_malformed_text();
    int start;
    start = live_items;
    while (live_items - start < 90) begin
      add_chars(int'($urandom_range(0, 4)));
      add_fault();
      add_chars(int'($urandom_range(0, 3)));
      send_text();
    end
  endtask

  task automatic test_byte_noise();
    int start;
    int k;
    start = live_items;
    while (live_items - start < 60) begin
      for (k = int'($urandom_range(1, 8)); k > 0; k--) queue_byte(8'($urandom));
      send_text();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_wellformed_text();
    test_malformed_text();
    test_byte_noise();
    s_axis_tvalid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_items.size() == 0) begin
      $display("tb_utf8_whitespace_collapser: done, clean");
    end else begin
      $display("tb_utf8_whitespace_collapser: done, errors");
    end
    $finish;
  end

endmodule
